### src/topic_ring_event_log_unit_assert.svh
// ----------------------------------------------------------------------------
// topic_ring_event_log_unit_assert.svh
// assertion macros shared by the event log modules
// ----------------------------------------------------------------------------
`ifndef TOPIC_RING_EVENT_LOG_UNIT_ASSERT_SVH
`define TOPIC_RING_EVENT_LOG_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define TREL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define TREL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TREL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define TREL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/trel_pkg.sv
// ----------------------------------------------------------------------------
// trel_pkg
// shared sizes, codes and control types of the topic event log
// ----------------------------------------------------------------------------
`default_nettype none

package trel_pkg;

    // log geometry
    localparam int TOPIC_COUNT   = 4;
    localparam int RING_DEPTH    = 16;
    localparam int PAYLOAD_LIMIT = 8;
    localparam int SUBJECT_LIMIT = 8;

    localparam int TI_W   = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;

    // stream widths
    localparam int IN_TDATA_W  = 152;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 248;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        OP_PUBLISH     = 2'd0,
        OP_SUBSCRIBE   = 2'd1,
        OP_UNSUBSCRIBE = 2'd2,
        OP_READ        = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SUBJECT = 3'd1,
        ST_TOPIC   = 3'd2,
        ST_PAYLOAD = 3'd3,
        ST_INDEX   = 3'd4,
        ST_CAP     = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic mem_rd;    // read the ring memory at the computed slot
        logic load_out;  // load the output register (and commit state)
        logic use_mem;   // output comes from the memory read data
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic fetch_needed;  // valid read that must go to the ring memory
        logic out_free;      // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

### src/trel_ctrl.sv
// ----------------------------------------------------------------------------
// trel_ctrl
// sequencer: accept, evaluate, optional memory fetch, hand off to output
// ----------------------------------------------------------------------------
`default_nettype none

`include "topic_ring_event_log_unit_assert.svh"

module trel_ctrl
    import trel_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_FETCH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.fetch_needed) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_FETCH;
                end else if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FETCH: begin
                // read data register holds while the output side stalls
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.use_mem  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TREL_ASSERT_IMP(a_load_needs_room, i_clk, i_rst_n, o_cmd.load_out, i_stat.out_free)
    `TREL_ASSERT_IMP(a_fetch_after_read, i_clk, i_rst_n, r_state == S_FETCH, $past(o_cmd.mem_rd) || $past(r_state == S_FETCH))
    `TREL_ASSERT_IMP(a_ready_in_idle, i_clk, i_rst_n, o_s_axis_tready, r_state == S_IDLE)

endmodule

`default_nettype wire

### src/trel_dp.sv
// ----------------------------------------------------------------------------
// trel_dp
// datapath: operand capture, checks, per-topic counters, ring memory, output
// ----------------------------------------------------------------------------
`default_nettype none

`include "topic_ring_event_log_unit_assert.svh"

module trel_dp
    import trel_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic [OUT_TUSER_W-1:0]      o_m_axis_tuser,
    input  wire t_ctrl_cmd              i_cmd,
    output t_dp_stat                    o_stat
);

    typedef struct packed {
        logic [63:0] seq;
        logic [63:0] corr;
        logic [63:0] pay;
        logic [3:0]  len;
        logic [2:0]  target;
        logic [2:0]  actor;
    } t_slot;

    // captured transaction
    t_opcode     r_op;
    logic [3:0]  r_actor;
    logic [2:0]  r_topic;
    logic [3:0]  r_target;
    logic [63:0] r_corr;
    logic [3:0]  r_len;
    logic [63:0] r_pay;
    logic [3:0]  r_pos;
    logic        r_cap;

    // per-topic state
    logic [SLOT_W-1:0] r_wp   [TOPIC_COUNT];
    logic [CNT_W-1:0]  r_held [TOPIC_COUNT];
    logic [31:0]       r_drop [TOPIC_COUNT];
    logic [7:0]        r_subs [TOPIC_COUNT];
    logic [63:0]       r_next_seq;

    // ring memory, no reset: reads only reach written slots
    t_slot r_mem [TOPIC_COUNT][RING_DEPTH];
    t_slot r_rd;

    // output register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [63:0] r_out_seq;
    logic [4:0]  r_out_stored;
    logic [31:0] r_out_drop;
    logic [7:0]  r_out_subs;
    logic [2:0]  r_out_actor;
    logic [2:0]  r_out_target;
    logic [63:0] r_out_corr;
    logic [3:0]  r_out_len;
    logic [63:0] r_out_pay;

    logic              topic_ok;
    logic              actor_ok;
    logic              target_ok;
    logic              len_ok;
    logic              pos_ok;
    logic [TI_W-1:0]   ti;
    logic [SLOT_W-1:0] cur_wp;
    logic [CNT_W-1:0]  cur_held;
    logic [31:0]       cur_drop;
    logic [7:0]        cur_subs;
    t_status           status;
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] n_wp_sel;
    logic [CNT_W-1:0]  n_held_sel;
    logic [31:0]       n_drop_sel;
    logic [7:0]        n_subs_sel;
    logic [7:0]        subject_bit;
    logic [63:0]       pay_mask;
    logic              do_commit;
    logic              pub_commit;
    t_slot             wr_slot;

    assign topic_ok  = (r_topic != 3'd0) && (r_topic <= 3'(TOPIC_COUNT));
    assign actor_ok  = r_actor < 4'(SUBJECT_LIMIT);
    assign target_ok = r_target < 4'(SUBJECT_LIMIT);
    assign len_ok    = r_len <= 4'(PAYLOAD_LIMIT);
    assign ti        = TI_W'(r_topic - 3'd1);

    assign cur_wp   = r_wp[ti];
    assign cur_held = r_held[ti];
    assign cur_drop = r_drop[ti];
    assign cur_subs = r_subs[ti];

    assign pos_ok = 5'(r_pos) < 5'(cur_held);

    // oldest entry sits at the write pointer once the ring has filled
    assign start_slot = (cur_held == CNT_W'(RING_DEPTH)) ? cur_wp : '0;
    assign slot_sum   = (SLOT_W+1)'(start_slot) + (SLOT_W+1)'(r_pos);
    assign rd_slot    = (slot_sum >= (SLOT_W+1)'(RING_DEPTH))
                      ? SLOT_W'(slot_sum - (SLOT_W+1)'(RING_DEPTH))
                      : SLOT_W'(slot_sum);

    always_comb begin
        status = ST_OK;
        case (r_op)
            OP_PUBLISH: begin
                if (!actor_ok || !target_ok) status = ST_SUBJECT;
                else if (!topic_ok)          status = ST_TOPIC;
                else if (!len_ok)            status = ST_PAYLOAD;
                else if (!r_cap)             status = ST_CAP;
            end
            OP_SUBSCRIBE, OP_UNSUBSCRIBE: begin
                if (!actor_ok)      status = ST_SUBJECT;
                else if (!topic_ok) status = ST_TOPIC;
                else if (!r_cap)    status = ST_CAP;
            end
            OP_READ: begin
                if (!topic_ok)    status = ST_TOPIC;
                else if (!pos_ok) status = ST_INDEX;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign do_commit  = i_cmd.load_out && !i_cmd.use_mem && (status == ST_OK);
    assign pub_commit = do_commit && (r_op == OP_PUBLISH);

    assign o_stat.fetch_needed = (r_op == OP_READ) && (status == ST_OK);
    assign o_stat.out_free     = !r_out_valid || i_m_axis_tready;

    assign subject_bit = 8'(1) << r_actor[2:0];

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            pay_mask[b*8 +: 8] = (4'(b) < r_len) ? 8'hFF : 8'h00;
        end
    end

    // topic state after the transaction
    always_comb begin
        n_wp_sel   = cur_wp;
        n_held_sel = cur_held;
        n_drop_sel = cur_drop;
        n_subs_sel = cur_subs;
        if (do_commit) begin
            case (r_op)
                OP_PUBLISH: begin
                    n_wp_sel = (cur_wp == SLOT_W'(RING_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
                    if (cur_held != CNT_W'(RING_DEPTH)) begin
                        n_held_sel = cur_held + 1'b1;
                    end else if (cur_drop != DROP_MAX) begin
                        n_drop_sel = cur_drop + 32'd1;
                    end
                end
                OP_SUBSCRIBE:   n_subs_sel = cur_subs | subject_bit;
                OP_UNSUBSCRIBE: n_subs_sel = cur_subs & ~subject_bit;
                default: begin
                    n_subs_sel = cur_subs;
                end
            endcase
        end
    end

    assign wr_slot.seq    = r_next_seq;
    assign wr_slot.corr   = r_corr;
    assign wr_slot.pay    = r_pay & pay_mask;
    assign wr_slot.len    = r_len;
    assign wr_slot.target = r_target[2:0];
    assign wr_slot.actor  = r_actor[2:0];

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_opcode'(i_s_axis_tuser[1:0]);
            r_actor  <= i_s_axis_tdata[3:0];
            r_topic  <= i_s_axis_tdata[6:4];
            r_target <= i_s_axis_tdata[10:7];
            r_corr   <= i_s_axis_tdata[74:11];
            r_len    <= i_s_axis_tdata[78:75];
            r_pay    <= i_s_axis_tdata[142:79];
            r_pos    <= i_s_axis_tdata[146:143];
            r_cap    <= i_s_axis_tdata[147];
        end
    end

    // per-topic counters and the global sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TOPIC_COUNT; t++) begin
                r_wp[t]   <= '0;
                r_held[t] <= '0;
                r_drop[t] <= '0;
                r_subs[t] <= '0;
            end
            r_next_seq <= '0;
        end else begin
            if (do_commit) begin
                r_wp[ti]   <= n_wp_sel;
                r_held[ti] <= n_held_sel;
                r_drop[ti] <= n_drop_sel;
                r_subs[ti] <= n_subs_sel;
            end
            if (pub_commit) begin
                r_next_seq <= r_next_seq + 64'd1;
            end
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pub_commit) begin
            r_mem[ti][cur_wp] <= wr_slot;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[ti][rd_slot];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.use_mem ? ST_OK : status;
            if (i_cmd.use_mem)   r_out_seq <= r_rd.seq;
            else if (pub_commit) r_out_seq <= r_next_seq;
            else                 r_out_seq <= '0;
            r_out_stored <= topic_ok ? 5'(n_held_sel) : 5'd0;
            r_out_drop   <= topic_ok ? n_drop_sel : 32'd0;
            r_out_subs   <= topic_ok ? n_subs_sel : 8'd0;
            r_out_actor  <= i_cmd.use_mem ? r_rd.actor  : 3'd0;
            r_out_target <= i_cmd.use_mem ? r_rd.target : 3'd0;
            r_out_corr   <= i_cmd.use_mem ? r_rd.corr   : 64'd0;
            r_out_len    <= i_cmd.use_mem ? r_rd.len    : 4'd0;
            r_out_pay    <= i_cmd.use_mem ? r_rd.pay    : 64'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {1'b0, r_out_pay, r_out_len, r_out_corr, r_out_target,
                              r_out_actor, r_out_subs, r_out_drop, r_out_stored, r_out_seq};

    `TREL_ASSERT_IMP(a_held_in_range, i_clk, i_rst_n, topic_ok, cur_held <= CNT_W'(RING_DEPTH))
    `TREL_ASSERT_IMP(a_drop_only_when_full, i_clk, i_rst_n, topic_ok && (cur_drop != '0), cur_held == CNT_W'(RING_DEPTH))
    `TREL_ASSERT_NXT(a_seq_advances, i_clk, i_rst_n, pub_commit, r_next_seq == $past(r_next_seq) + 64'd1)

endmodule

`default_nettype wire

### src/topic_ring_event_log_unit.sv
// sequence: accept in S_IDLE, evaluate in S_EVAL, then load the output register once it is free;
// a valid read of a stored entry passes S_FETCH first; a new transaction is taken only in S_IDLE
// S_FETCH serves the registered read port of the ring memory
// a stalled output holds one result while the next transaction is taken and evaluated
// reset (i_rst_n low, synchronous) clears counters, subscriber masks and the sequence
// ring memory is not cleared: no clearing pass, reads only reach written slots
// ----------------------------------------------------------------------------
// topic_ring_event_log_unit
// per-topic overwriting ring event log with publish, subscribe and read
// ----------------------------------------------------------------------------
`default_nettype none

module topic_ring_event_log_unit
    import trel_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // actor_subject[3:0], topic_number[6:4], target_subject[10:7],
    // correlation_tag[74:11], payload_length[78:75], payload_bytes[142:79],
    // entry_position[146:143], capability_granted[147], zero pad[151:148]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode[1:0]
    input  wire logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // sequence_number[63:0], stored_count[68:64], drop_count[100:69],
    // subscriber_mask[108:101], entry_actor[111:109], entry_target[114:112],
    // entry_correlation[178:115], entry_length[182:179],
    // entry_payload[246:183], zero pad[247]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // status[2:0]
    output logic [OUT_TUSER_W-1:0]      o_m_axis_tuser
);

    // controller/datapath handshake
    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencer: one transaction in flight, waits on the output register
    trel_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // checks, topic counters, ring memory and the result register
    trel_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

endmodule

`default_nettype wire
